### design/assert_macros.svh
// assert_macros.svh: assertion macros shared by the text console rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock outside reset
`define TCW_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tcw_pkg.sv
// tcw_pkg: types and fixed constants of the text console writer
// no dependencies; imported by every module of the block but tcw_ram
`default_nettype none

package tcw_pkg;

    // fixed field widths of the ports
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int POS_OUT_W  = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // character codes and attributes
    localparam logic [CHAR_W-1:0] NULL_CODE       = 8'h00;
    localparam logic [CHAR_W-1:0] LINE_FEED       = 8'h0a;
    localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'h0d;
    localparam logic [CHAR_W-1:0] BLANK_CODE      = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR      = 8'h07;

    // command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_DONE
    } tcw_state_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_CLEAR,
        MEM_COPY,
        MEM_BLANK
    } tcw_mem_op_t;

    // controller to datapath
    typedef struct packed {
        logic        capture;
        logic        exec_put;
        logic        rd_cell;
        logic        clear_cell;
        logic        load_cell;
        logic        scan_zero;
        logic        scan_inc;
        tcw_mem_op_t mem_op;
        logic        load_out;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic in_range;
        logic scrolls;
        logic scan_last_copy;
        logic scan_last;
    } tcw_status_t;

endpackage

`default_nettype wire

### design/tcw_ram.sv
// tcw_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/tcw_regs.sv
// tcw_regs: apb configuration register (text attribute)
// depends on tcw_pkg
`default_nettype none

module tcw_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tcw_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output logic      [tcw_pkg::ATTR_W-1:0]     text_attribute
);

    import tcw_pkg::*;

    logic              attr_sel;
    logic              attr_wr;
    logic [ATTR_W-1:0] attr_reg;

    // decode
    assign pready   = 1'b1;
    assign attr_sel = (paddr[2] == REG_TEXT_ATTR);
    assign attr_wr  = psel & penable & pwrite & pready & attr_sel;

    // attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (attr_wr)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    // read data, aligned accesses only
    always_comb
    begin
        prdata = '0;
        if (attr_sel && (paddr[1:0] == 2'b00))
        begin
            prdata = {{(APB_DATA_W-ATTR_W){1'b0}}, attr_reg};
        end
    end

    assign text_attribute = attr_reg;

endmodule

`default_nettype wire

### design/tcw_ctrl.sv
// tcw_ctrl: controller state machine of the text console writer
// depends on tcw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);

    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;
    logic       out_valid_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_read)
                begin
                    state_next = status.in_range ? ST_READ : ST_DONE;
                end
                else
                begin
                    state_next = status.scrolls ? ST_COPY : ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_COPY:
            begin
                if (status.scan_last_copy)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.mem_op = MEM_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_op   = MEM_CLEAR;
                cmd.scan_inc = !status.scan_last;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.scan_zero = 1'b1;
                cmd.capture   = in_valid;
            end
            ST_EXEC:
            begin
                cmd.clear_cell = 1'b1;
                if (status.is_read)
                begin
                    cmd.rd_cell = status.in_range;
                end
                else
                begin
                    cmd.exec_put = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.load_cell = 1'b1;
            end
            ST_COPY:
            begin
                cmd.mem_op   = MEM_COPY;
                cmd.scan_inc = !status.scan_last_copy;
            end
            ST_BLANK:
            begin
                cmd.mem_op   = MEM_BLANK;
                cmd.scan_inc = !status.scan_last;
            end
            ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd.mem_op = MEM_NONE;
            end
        endcase
    end

    // result valid flag of the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `TCW_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready, "result overwritten before taken")
    `TCW_ASSERT_NEXT(a_clear_once, clk, rst_n, state_reg != ST_CLEAR, state_reg != ST_CLEAR, "clearing pass restarted")
    `TCW_ASSERT_IMPLY(a_copy_entry, clk, rst_n, $rose(state_reg == ST_COPY), $past(state_reg) == ST_EXEC, "scroll started outside a put")

endmodule

`default_nettype wire

### design/tcw_dpath.sv
// tcw_dpath: cursor registers, screen store and result registers
// depends on tcw_pkg, tcw_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tcw_dpath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tcw_pkg::tcw_cmd_t             cmd,
    output tcw_pkg::tcw_status_t               status,
    input  wire logic                          command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    text_attribute,
    output logic      [tcw_pkg::COL_OUT_W-1:0] cursor_col,
    output logic      [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
    output logic      [tcw_pkg::POS_OUT_W-1:0] cursor_position,
    output logic      [tcw_pkg::CHAR_W-1:0]    cell_char,
    output logic      [tcw_pkg::ATTR_W-1:0]    cell_attr
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int WORD_W = ATTR_W + CHAR_W;

    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 cmd_reg;
    logic [CHAR_W-1:0]    code_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic [ADDR_W-1:0]    scan_reg;
    logic [CHAR_W-1:0]    cell_char_reg;
    logic [ATTR_W-1:0]    cell_attr_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [POS_OUT_W-1:0] out_pos_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [ATTR_W-1:0]    out_attr_reg;

    logic                 is_null;
    logic                 is_lf;
    logic                 is_cr;
    logic                 printable;
    logic                 col_last;
    logic                 row_last;
    logic                 row_wrap;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_next;
    logic [ADDR_W-1:0]    cursor_addr;
    logic                 scan_last_copy;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]    ram_wr_data;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            code_reg  <= char_code;
            index_reg <= cell_index;
        end
    end

    // character decode and cursor advance
    assign is_null   = (code_reg == NULL_CODE);
    assign is_lf     = (code_reg == LINE_FEED);
    assign is_cr     = (code_reg == CARRIAGE_RETURN);
    assign printable = !is_null && !is_lf && !is_cr;
    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last  = (row_reg == ROW_W'(ROWS - 1));
    assign row_wrap  = is_lf || (printable && col_last);

    always_comb
    begin
        col_next = col_reg;
        if (is_lf || is_cr || (printable && col_last))
        begin
            col_next = '0;
        end
        else if (printable)
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // row stays on the last row when the screen scrolls
    assign row_next = (row_wrap && !row_last) ? row_reg + ROW_W'(1) : row_reg;

    assign cursor_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));

    // cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.exec_put)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // sweep counter for clearing, copying and blanking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_zero)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + ADDR_W'(1);
        end
    end

    assign scan_last_copy = (scan_reg == ADDR_W'(CELLS - COLUMNS));

    // status to the controller
    always_comb
    begin
        status                = '0;
        status.is_read        = (cmd_reg == CMD_READ);
        status.in_range       = (32'(index_reg) < CELLS);
        status.scrolls        = row_wrap && row_last;
        status.scan_last_copy = scan_last_copy;
        status.scan_last      = (scan_reg == ADDR_W'(CELLS - 1));
    end

    // screen store port selection
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = scan_reg;
        ram_wr_data = {RESET_ATTR, NULL_CODE};
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(index_reg);
        case (cmd.mem_op)
            MEM_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            MEM_COPY:
            begin
                // read one row ahead, write the word read last cycle
                ram_wr_en   = (scan_reg != '0);
                ram_wr_addr = scan_reg - ADDR_W'(1);
                ram_wr_data = ram_rd_data;
                ram_rd_en   = !scan_last_copy;
                ram_rd_addr = scan_reg + ADDR_W'(COLUMNS);
            end
            MEM_BLANK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {text_attribute, BLANK_CODE};
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
        if (cmd.exec_put && printable)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cursor_addr;
            ram_wr_data = {text_attribute, code_reg};
        end
        if (cmd.rd_cell)
        begin
            ram_rd_en = 1'b1;
        end
    end

    tcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // read cell holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.clear_cell)
        begin
            cell_char_reg <= '0;
            cell_attr_reg <= '0;
        end
        else if (cmd.load_cell)
        begin
            cell_char_reg <= ram_rd_data[CHAR_W-1:0];
            cell_attr_reg <= ram_rd_data[WORD_W-1:CHAR_W];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_col_reg  <= COL_OUT_W'(col_reg);
            out_row_reg  <= ROW_OUT_W'(row_reg);
            out_pos_reg  <= POS_OUT_W'(cursor_addr);
            out_char_reg <= cell_char_reg;
            out_attr_reg <= cell_attr_reg;
        end
    end

    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_position = out_pos_reg;
    assign cell_char       = out_char_reg;
    assign cell_attr       = out_attr_reg;

    // checks
    `TCW_ASSERT_ALWAYS(a_row_range, clk, rst_n, 32'(row_reg) < ROWS, "cursor row past last row")
    `TCW_ASSERT_ALWAYS(a_col_range, clk, rst_n, 32'(col_reg) < COLUMNS, "cursor column past last column")
    `TCW_ASSERT_IMPLY(a_wr_range, clk, rst_n, ram_wr_en, 32'(ram_wr_addr) < CELLS, "screen write outside store")

endmodule

`default_nettype wire

### design/text_console_writer_top.sv
// text console writer: a COLUMNS by ROWS character-cell screen with a cursor.
// Request channel (in_valid/in_ready): command 0 puts char_code at the cursor
// (line feed, carriage return and code 0 handled as control), command 1 reads
// the cell at cell_index. Each request yields one result on the out_valid /
// out_ready channel with the cursor column, row and linear position and, for a
// read, the cell's character and attribute (zero for a put or an index past
// the screen). The text attribute is written through the apb port.
// Sequence: an accepted request passes through EXEC, then READ for an in-range
// read, then DONE, which loads the output register, and returns to IDLE.
// A put that moves past the last row scrolls the screen through the single
// write/read port of the screen ram, one word a cycle, in the COPY and BLANK
// states before its result is loaded.
// Reset clears the cursor and then sweeps the screen ram to character 0 with
// attribute 7, one word a cycle (COLUMNS*ROWS words, 2000 by default); in_ready
// stays low meanwhile while apb writes are taken.
// A stalled receiver holds the result in the output register; one further
// request may be accepted and worked on, and its result waits until the
// register is free.
// Depends on tcw_pkg, tcw_regs, tcw_ctrl, tcw_dpath and tcw_ram.
`default_nettype none

module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]    cell_index,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [tcw_pkg::COL_OUT_W-1:0]  cursor_col,
    output logic      [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
    output logic      [tcw_pkg::POS_OUT_W-1:0]  cursor_position,
    output logic      [tcw_pkg::CHAR_W-1:0]     cell_char,
    output logic      [tcw_pkg::ATTR_W-1:0]     cell_attr,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tcw_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    import tcw_pkg::*;

    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic [ATTR_W-1:0] text_attribute;

    // configuration register
    tcw_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_attribute (text_attribute)
    );

    // controller
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .command         (command),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .text_attribute  (text_attribute),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr)
    );

endmodule

`default_nettype wire

### tb/tb_text_console_writer_top.sv
// testbench for text_console_writer_top: random and directed put/read requests,
// a request-level predictor of cursor and screen store, apb writes of the attribute
// depends on tcw_pkg and the text console writer rtl
module tb_text_console_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // attribute register byte address
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

    // every request scrolling, both sides at longest idle, several times over
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned SETTLE      = 16;
    localparam int unsigned DRAIN       = CELLS + 16;
    localparam int unsigned PHASE_ITEMS = 160;

    typedef struct packed {
        logic                cmd;
        logic [CHAR_W-1:0]   code;
        logic [INDEX_W-1:0]  idx;
    } console_req_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] pos;
        logic [CHAR_W-1:0]    ch;
        logic [ATTR_W-1:0]    attr;
    } console_result_t;

    // dut signals
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  command    = CMD_PUT;
    logic [CHAR_W-1:0]     char_code  = '0;
    logic [INDEX_W-1:0]    cell_index = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [COL_OUT_W-1:0]  cursor_col;
    logic [ROW_OUT_W-1:0]  cursor_row;
    logic [POS_OUT_W-1:0]  cursor_position;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // console model state
    logic [15:0]           screen_model [CELLS];
    int unsigned           model_col;
    int unsigned           model_row;
    logic [ATTR_W-1:0]     model_attr;

    // request and result bookkeeping
    console_req_t          pending_requests [$];
    console_result_t       due_results [$];
    console_req_t          offered_req;
    int unsigned           mismatch_count = 0;
    int unsigned           cycle_count    = 0;

    // idle control of both sides
    int unsigned           send_wait      = 0;
    int unsigned           send_stretch   = 0;
    bit                    send_calm      = 1'b0;
    int unsigned           recv_wait      = 0;
    int unsigned           recv_stretch   = 0;
    bit                    recv_calm      = 1'b0;
    int unsigned           hold_left      = 0;
    int unsigned           hold_kick      = 0;
    int unsigned           hold_seen      = 0;

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .cursor_position(cursor_position),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // console model: reset contents
    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = {RESET_ATTR, NULL_CODE};
        model_col  = 0;
        model_row  = 0;
        model_attr = RESET_ATTR;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // scroll the model up one row and blank the bottom row
    task automatic scroll_model();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {model_attr, BLANK_CODE};
        model_row = ROWS - 1;
    endtask

    // apply one request to the model and form its result
    task automatic apply_console_request(input console_req_t req,
                                         output console_result_t res);
        int unsigned cell_addr;
        int unsigned pos;
        res = '0;
        if (req.cmd == CMD_PUT)
        begin
            if (req.code == LINE_FEED)
            begin
                model_col = 0;
                model_row++;
            end
            else if (req.code == CARRIAGE_RETURN)
            begin
                model_col = 0;
            end
            else if (req.code != NULL_CODE)
            begin
                cell_addr = model_row * COLUMNS + model_col;
                if (cell_addr < CELLS)
                    screen_model[cell_addr] = {model_attr, req.code};
                model_col++;
                if (model_col >= COLUMNS)
                begin
                    model_col = 0;
                    model_row++;
                end
            end
            if (model_row >= ROWS)
                scroll_model();
        end
        else if (req.idx < CELLS)
        begin
            res.ch   = screen_model[req.idx][7:0];
            res.attr = screen_model[req.idx][15:8];
        end
        pos     = model_row * COLUMNS + model_col;
        res.col = model_col[COL_OUT_W-1:0];
        res.row = model_row[ROW_OUT_W-1:0];
        res.pos = pos[POS_OUT_W-1:0];
    endtask

    // idle draw: calm stretches give no gaps, others a random gap
    function automatic int unsigned next_gap(inout int unsigned stretch, inout bit calm);
        if (stretch == 0)
        begin
            calm    = ($urandom_range(0, 2) == 0);
            stretch = $urandom_range(8, 48);
        end
        stretch--;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        console_result_t res;
        logic            offering;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                apply_console_request(offered_req, res);
                due_results.push_back(res);
                offering  = 1'b0;
                send_wait = next_gap(send_stretch, send_calm);
            end
            if (!offering)
            begin
                if (send_wait != 0)
                    send_wait--;
                else if (pending_requests.size() != 0)
                begin
                    offered_req = pending_requests.pop_front();
                    command    <= offered_req.cmd;
                    char_code  <= offered_req.code;
                    cell_index <= offered_req.idx;
                    offering   = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // long receiver hold-off, kicked from the stimulus
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        console_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("unexpected result, cursor_position",
                                    32'(cursor_position), 0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (cursor_col !== want.col)
                        report_mismatch("cursor_col", 32'(cursor_col), 32'(want.col));
                    if (cursor_row !== want.row)
                        report_mismatch("cursor_row", 32'(cursor_row), 32'(want.row));
                    if (cursor_position !== want.pos)
                        report_mismatch("cursor_position", 32'(cursor_position),
                                        32'(want.pos));
                    if (cell_char !== want.ch)
                        report_mismatch("cell_char", 32'(cell_char), 32'(want.ch));
                    if (cell_attr !== want.attr)
                        report_mismatch("cell_attr", 32'(cell_attr), 32'(want.attr));
                end
                recv_wait = next_gap(recv_stretch, recv_calm);
            end
            else if (recv_wait != 0)
            begin
                recv_wait--;
            end
            out_ready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // apb access tasks
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the attribute, keep the model copy, and read it back
    task automatic set_text_attr(input logic [ATTR_W-1:0] attr);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rdata;
        wdata      = $urandom();
        wdata[7:0] = attr;
        apb_write(ATTR_ADDR, wdata);
        model_attr = attr;
        apb_read(ATTR_ADDR, rdata);
        if (rdata[7:0] !== attr)
            report_mismatch("text_attribute readback", 32'(rdata[7:0]), 32'(attr));
    endtask

    task automatic push_req(input logic cmd, input logic [CHAR_W-1:0] code,
                            input logic [INDEX_W-1:0] idx);
        console_req_t req;
        req.cmd  = cmd;
        req.code = code;
        req.idx  = idx;
        pending_requests.push_back(req);
    endtask

    task automatic push_put(input logic [CHAR_W-1:0] code);
        push_req(CMD_PUT, code, INDEX_W'($urandom_range(0, 2047)));
    endtask

    task automatic push_read(input logic [INDEX_W-1:0] idx);
        push_req(CMD_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    // printable-ish code, never a control code
    function automatic logic [CHAR_W-1:0] text_code();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(1, 255));
        if (c == LINE_FEED || c == CARRIAGE_RETURN)
            c = BLANK_CODE;
        return c;
    endfunction

    // read index: anywhere, the bottom rows where text lands, or past the screen
    function automatic logic [INDEX_W-1:0] pick_cell();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return INDEX_W'($urandom_range(0, CELLS - 1));
        else if (r < 9)
            return INDEX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
        else
            return INDEX_W'($urandom_range(CELLS, 2047));
    endfunction

    // directed requests: field extremes, control codes, null code, reads out of range
    task automatic fill_directed();
        push_req(CMD_READ, 8'hff, '0);
        push_req(CMD_READ, 8'h00, INDEX_W'(CELLS - 1));
        push_req(CMD_READ, 8'hff, INDEX_W'(CELLS));
        push_req(CMD_READ, 8'h00, 11'h7ff);
        push_req(CMD_PUT, NULL_CODE, 11'h7ff);
        push_req(CMD_PUT, 8'hff, '0);
        push_put(8'h01);
        push_put(BLANK_CODE);
        push_put(CARRIAGE_RETURN);
        push_put(8'h41);
        push_put(8'h80);
        push_put(NULL_CODE);
        push_put(LINE_FEED);
        push_put(8'h7f);
        push_read('0);
        push_read(INDEX_W'(1));
        push_read(INDEX_W'(COLUMNS));
        push_put(LINE_FEED);
        push_put(CARRIAGE_RETURN);
        push_read(INDEX_W'(2 * COLUMNS));
        push_read(INDEX_W'(COLUMNS + 1));
    endtask

    // random requests in bursts: text lines, read runs, blank lines, noise
    task automatic fill_random(input int unsigned count);
        int unsigned added;
        int unsigned kind;
        int unsigned len;
        int unsigned term;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                // text line, sometimes long enough to wrap
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100)
                                                  : $urandom_range(0, 12);
                for (int i = 0; i < len; i++)
                    push_put(($urandom_range(0, 39) == 0) ? NULL_CODE : text_code());
                added += len;
                term = $urandom_range(0, 5);
                if (term == 0)
                begin
                    push_put(CARRIAGE_RETURN);
                    added += 1;
                end
                else if (term == 1)
                begin
                    push_put(CARRIAGE_RETURN);
                    push_put(LINE_FEED);
                    added += 2;
                end
                else if (term != 2)
                begin
                    push_put(LINE_FEED);
                    added += 1;
                end
            end
            else if (kind < 8)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_read(pick_cell());
                added += len;
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_put(LINE_FEED);
                added += len;
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_req(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                             INDEX_W'($urandom_range(0, 2047)));
                added += len;
            end
        end
    endtask

    // block idle: nothing queued, nothing offered, nothing due
    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // test sequence
    initial
    begin : stimulus
        logic [ATTR_W-1:0] phase_attr [4];
        phase_attr[0] = 8'h00;
        phase_attr[1] = ATTR_W'($urandom_range(1, 254));
        phase_attr[2] = ATTR_W'($urandom_range(1, 254));
        phase_attr[3] = 8'hff;

        @(posedge rst_n);
        set_text_attr(8'hff);
        @(negedge clk);
        fill_directed();
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            repeat (SETTLE) @(posedge clk);
            set_text_attr(phase_attr[p]);
            // long receiver stall while requests keep coming
            if (p == 0 || p == 2)
                hold_kick <= hold_kick + 1;
            @(negedge clk);
            fill_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_regs.sv
design/tcw_ctrl.sv
design/tcw_dpath.sv
design/text_console_writer_top.sv
tb/tb_text_console_writer_top.sv
